FILE: src/tensor_contraction_mac_assert.svh
// assertion macros shared by the tensor contraction checker
`ifndef TENSOR_CONTRACTION_MAC_ASSERT_SVH
`define TENSOR_CONTRACTION_MAC_ASSERT_SVH

// condition in one cycle implies consequence in the next, ignored during reset
`define TCM_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

// condition implies consequence in the same cycle, ignored during reset
`define TCM_ASSERT_NOW(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// consequence that must hold in the cycle after reset is high
`define TCM_ASSERT_RST(label, clk, rst, post, msg) \
  label: assert property (@(posedge clk) (rst) |=> (post)) else $error(msg);

`endif

FILE: src/tcm_pkg.sv
// shared types, widths, codes and constants of the tensor contraction block
package tcm_pkg;

  // field widths
  localparam int FUNC_W    = 2;
  localparam int IDX_W     = 10;
  localparam int VAL_W     = 32;
  localparam int DIM_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int FRAC_W    = 16;

  // flat operand index inside the product loop
  localparam int LIN_W = 2 * DIM_W;

  // exact accumulator: full 64-bit products, up to 63 terms
  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W  = PROD_W + DIM_W;

  // upper bits of the rounded sum that must all match the sign
  localparam int SAT_LO = FRAC_W + VAL_W - 1;

  // divider step counter
  localparam int DIV_CNT_W = $clog2(IDX_W);

  // sizes
  localparam int MAX_DIM     = 32;
  localparam int STORE_DEPTH = 1024;

  // request codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD_LEFT  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_RIGHT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPUTE    = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_OUTER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMON      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_OUTER = 2'd2;

  // saturation bounds and rounding offset
  localparam logic [VAL_W-1:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [VAL_W-1:0] Q_MIN = 32'h8000_0000;
  localparam logic [ACC_W-1:0] ROUND_HALF = {{(ACC_W - FRAC_W){1'b0}}, 16'h8000};

  typedef logic [DIM_W-1:0] dim_t;

  // register value as used: zero acts as one, large values clip to the maximum
  function automatic dim_t eff_size(input dim_t reg_val);
    dim_t res;
    if (reg_val == '0) begin
      res = dim_t'(1);
    end else if (int'(reg_val) > MAX_DIM) begin
      res = dim_t'(MAX_DIM);
    end else begin
      res = reg_val;
    end
    return res;
  endfunction

endpackage

FILE: src/tensor_contraction_mac.sv
// top level of the tensor contraction block: operand stores, divider and shared mac
//
// Input channel (in_valid / in_stall) takes one request per handshake: load
//   left / load right write element_value at element_index into the matching
//   store; a compute asks for one result at result_position.
// Output channel (out_valid / out_stall) returns sum_value, out_position and
//   saturated for every compute whose position lies inside rows x columns.
// Sizes come from three 6-bit registers on cfg_we / cfg_index / cfg_data,
//   to be written while the block is idle; the block itself does not enforce this.
// Loads never make the block busy. A compute holds in_stall high while it
//   runs 10 divider steps for row and column, a base-index step, cs mac
//   steps through the single 32x32 multiplier (cs being the clipped common
//   length), the pipeline drain, rounding and the load of the output
//   register, which raises out_valid.
// A new compute is taken only once the block is back in idle.
// The output register holds a result while the receiver stalls; loads are
//   still taken, and a following compute waits at its last step.
// Reset clears the sizes to one, empties the output register and returns the
//   sequencer to idle; store contents are undefined until written.
module tensor_contraction_mac #(
  parameter int STORE_DEPTH = tcm_pkg::STORE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [tcm_pkg::FUNC_W-1:0]          func,
  input  logic [tcm_pkg::IDX_W-1:0]           element_index,
  input  logic signed [tcm_pkg::VAL_W-1:0]    element_value,
  input  logic [tcm_pkg::IDX_W-1:0]           result_position,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tcm_pkg::VAL_W-1:0]    sum_value,
  output logic [tcm_pkg::IDX_W-1:0]           out_position,
  output logic                                saturated,
  // configuration
  input  logic                                cfg_we,
  input  logic [tcm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tcm_pkg::DIM_W-1:0]           cfg_data
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = (AW + 1 > tcm_pkg::LIN_W) ? AW + 1 : tcm_pkg::LIN_W;
  localparam logic [CW-1:0] DEPTH_CW = CW'(STORE_DEPTH);
  localparam logic [tcm_pkg::DIV_CNT_W-1:0] DIV_LAST =
    tcm_pkg::DIV_CNT_W'(tcm_pkg::IDX_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_BASE,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND,
    ST_FINISH
  } state_t;

  state_t state;

  // size registers
  logic [tcm_pkg::DIM_W-1:0] left_outer_size;
  logic [tcm_pkg::DIM_W-1:0] inner_size;
  logic [tcm_pkg::DIM_W-1:0] right_outer_size;
  logic [tcm_pkg::DIM_W-1:0] rows;
  logic [tcm_pkg::DIM_W-1:0] cs;
  logic [tcm_pkg::DIM_W-1:0] cols;
  logic [tcm_pkg::LIN_W-1:0] area;
  logic                      pos_ok;

  // operand stores
  logic [tcm_pkg::VAL_W-1:0] left_mem  [STORE_DEPTH];
  logic [tcm_pkg::VAL_W-1:0] right_mem [STORE_DEPTH];
  logic signed [tcm_pkg::VAL_W-1:0] left_q;
  logic signed [tcm_pkg::VAL_W-1:0] right_q;
  logic [CW-1:0]             wr_cw;
  logic [AW-1:0]             wr_addr;
  logic                      wr_ok;
  logic                      left_we;
  logic                      right_we;

  // divider
  logic [tcm_pkg::IDX_W-1:0]     div_quo;
  logic [tcm_pkg::DIM_W-1:0]     div_rem;
  logic [tcm_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [tcm_pkg::DIM_W:0]       div_shift;
  logic [tcm_pkg::DIM_W:0]       div_diff;
  logic                          div_ge;

  // mac loop
  logic [tcm_pkg::IDX_W-1:0] pos_q;
  logic [tcm_pkg::LIN_W-1:0] base_idx;
  logic [tcm_pkg::LIN_W-1:0] left_idx;
  logic [tcm_pkg::LIN_W-1:0] right_idx;
  logic [tcm_pkg::DIM_W-1:0] k;
  logic [CW-1:0]             left_cw;
  logic [CW-1:0]             right_cw;
  logic [AW-1:0]             left_rd_addr;
  logic [AW-1:0]             right_rd_addr;
  logic                      left_in;
  logic                      right_in;
  logic                      left_zero;
  logic                      right_zero;
  logic                      rd_v;
  logic                      mul_v;
  logic signed [tcm_pkg::VAL_W-1:0]  left_opnd;
  logic signed [tcm_pkg::VAL_W-1:0]  right_opnd;
  logic signed [tcm_pkg::PROD_W-1:0] prod;
  logic signed [tcm_pkg::ACC_W-1:0]  acc;
  logic [tcm_pkg::ACC_W-1:0]         rnd;

  // saturation
  logic [tcm_pkg::ACC_W-1-tcm_pkg::SAT_LO:0] rnd_upper;
  logic                                      rnd_fits;
  logic [tcm_pkg::VAL_W-1:0]                 sum_next;

  // effective sizes and position range
  assign rows   = tcm_pkg::eff_size(left_outer_size);
  assign cs     = tcm_pkg::eff_size(inner_size);
  assign cols   = tcm_pkg::eff_size(right_outer_size);
  assign area   = tcm_pkg::LIN_W'(rows) * tcm_pkg::LIN_W'(cols);
  assign pos_ok = tcm_pkg::LIN_W'(result_position) < area;

  assign in_stall = (state != ST_IDLE);

  // load writes
  assign wr_cw    = CW'(element_index);
  assign wr_addr  = wr_cw[AW-1:0];
  assign wr_ok    = wr_cw < DEPTH_CW;
  assign left_we  = in_valid && !in_stall && (func == tcm_pkg::FUNC_LOAD_LEFT) && wr_ok;
  assign right_we = in_valid && !in_stall && (func == tcm_pkg::FUNC_LOAD_RIGHT) && wr_ok;

  // read addresses and range flags
  assign left_cw       = CW'(left_idx);
  assign right_cw      = CW'(right_idx);
  assign left_rd_addr  = left_cw[AW-1:0];
  assign right_rd_addr = right_cw[AW-1:0];
  assign left_in       = left_cw < DEPTH_CW;
  assign right_in      = right_cw < DEPTH_CW;

  // left store
  always_ff @(posedge clk) begin
    if (left_we) begin
      left_mem[wr_addr] <= element_value;
    end
    left_q <= left_mem[left_rd_addr];
  end

  // right store
  always_ff @(posedge clk) begin
    if (right_we) begin
      right_mem[wr_addr] <= element_value;
    end
    right_q <= right_mem[right_rd_addr];
  end

  // one restoring divider step
  assign div_shift = {div_rem, div_quo[tcm_pkg::IDX_W-1]};
  assign div_diff  = div_shift - {1'b0, cols};
  assign div_ge    = div_shift >= {1'b0, cols};

  // row times common size gives the first left index
  assign base_idx = tcm_pkg::LIN_W'(div_quo[tcm_pkg::DIM_W-1:0]) * tcm_pkg::LIN_W'(cs);

  // operands, zero outside the store
  assign left_opnd  = left_zero ? '0 : left_q;
  assign right_opnd = right_zero ? '0 : right_q;

  // rounded sum must fit in 32 bits
  assign rnd_upper = rnd[tcm_pkg::ACC_W-1:tcm_pkg::SAT_LO];
  assign rnd_fits  = (rnd_upper == '0) || (&rnd_upper);
  assign sum_next  = rnd_fits ? rnd[tcm_pkg::SAT_LO:tcm_pkg::FRAC_W] :
                     (rnd[tcm_pkg::ACC_W-1] ? tcm_pkg::Q_MIN : tcm_pkg::Q_MAX);

  // sequencer, mac pipeline and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      out_valid        <= 1'b0;
      rd_v             <= 1'b0;
      mul_v            <= 1'b0;
      left_outer_size  <= tcm_pkg::DIM_W'(1);
      inner_size       <= tcm_pkg::DIM_W'(1);
      right_outer_size <= tcm_pkg::DIM_W'(1);
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          tcm_pkg::CFG_LEFT_OUTER:  left_outer_size  <= cfg_data;
          tcm_pkg::CFG_COMMON:      inner_size       <= cfg_data;
          tcm_pkg::CFG_RIGHT_OUTER: right_outer_size <= cfg_data;
          default: ;
        endcase
      end

      // read, multiply, accumulate
      rd_v  <= (state == ST_MAC);
      mul_v <= rd_v;
      if (rd_v) begin
        prod <= left_opnd * right_opnd;
      end
      if (mul_v) begin
        acc <= acc + {{(tcm_pkg::ACC_W - tcm_pkg::PROD_W){prod[tcm_pkg::PROD_W-1]}}, prod};
      end

      // output register drains on a handshake unless a new result replaces it
      if (out_valid && !out_stall && (state != ST_FINISH)) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid && (func == tcm_pkg::FUNC_COMPUTE) && pos_ok) begin
            pos_q   <= result_position;
            div_quo <= result_position;
            div_rem <= '0;
            div_cnt <= '0;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          div_quo <= {div_quo[tcm_pkg::IDX_W-2:0], div_ge};
          div_rem <= div_ge ? div_diff[tcm_pkg::DIM_W-1:0] : div_shift[tcm_pkg::DIM_W-1:0];
          div_cnt <= div_cnt + tcm_pkg::DIV_CNT_W'(1);
          if (div_cnt == DIV_LAST) begin
            state <= ST_BASE;
          end
        end
        ST_BASE: begin
          left_idx  <= base_idx;
          right_idx <= tcm_pkg::LIN_W'(div_rem);
          k         <= '0;
          acc       <= '0;
          state     <= ST_MAC;
        end
        ST_MAC: begin
          left_zero  <= !left_in;
          right_zero <= !right_in;
          left_idx   <= left_idx + tcm_pkg::LIN_W'(1);
          right_idx  <= right_idx + tcm_pkg::LIN_W'(cols);
          k          <= k + tcm_pkg::DIM_W'(1);
          if (k == cs - tcm_pkg::DIM_W'(1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!rd_v && !mul_v) begin
            state <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          rnd   <= acc + tcm_pkg::ROUND_HALF;
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            sum_value    <= sum_next;
            out_position <= pos_q;
            saturated    <= !rnd_fits;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: src/tcm_checker.sv
// port-level checker of the tensor contraction block and its bind
`include "tensor_contraction_mac_assert.svh"

module tcm_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic [tcm_pkg::FUNC_W-1:0]       func,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [tcm_pkg::VAL_W-1:0] sum_value,
  input logic [tcm_pkg::IDX_W-1:0]        out_position,
  input logic                             saturated
);

  logic load_req;
  logic [tcm_pkg::VAL_W-1:0] sum_bits;

  assign load_req = in_valid && !in_stall &&
                    ((func == tcm_pkg::FUNC_LOAD_LEFT) || (func == tcm_pkg::FUNC_LOAD_RIGHT));
  assign sum_bits = sum_value;

  // a stalled result stays put
  `TCM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(sum_value) && $stable(out_position) && $stable(saturated), "stalled result changed")

  // a load never makes the block busy
  `TCM_ASSERT_NEXT(a_load_no_stall, clk, rst, load_req, !in_stall, "load request left the block busy")

  // a clipped sum sits at one of the two bounds
  `TCM_ASSERT_NOW(a_sat_bound, clk, rst, out_valid && saturated, (sum_bits == tcm_pkg::Q_MAX) || (sum_bits == tcm_pkg::Q_MIN), "saturated sum not at a bound")

  // a new result only follows a busy cycle
  `TCM_ASSERT_NOW(a_result_after_busy, clk, rst, $rose(out_valid), $past(in_stall), "result appeared without a compute")

  // reset leaves the block idle and empty
  `TCM_ASSERT_RST(a_reset_idle, clk, rst, !out_valid && !in_stall, "block not idle after reset")

endmodule

bind tensor_contraction_mac tcm_checker u_tcm_checker (.*);
